>>> hdl/ecu_pkg.sv
package ecu_pkg;

    localparam int unsigned SIN_N   = 256;
    localparam int unsigned IDX_W   = $clog2(SIN_N + 1);
    localparam int unsigned POS_W   = 16 + IDX_W;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [16:0] HALF_Q16 = 17'd32768;
    localparam longint SPRING_Q24   = 64'sd28547775;
    localparam longint SPRING1_Q24  = 64'sd45324991;
    localparam longint OUT_MIN      = -64'sd65536;
    localparam longint OUT_MAX      = 64'sd131071;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    localparam logic [3:0] CS_LINEAR     = 4'd0;
    localparam logic [3:0] CS_SINE_OUT   = 4'd1;
    localparam logic [3:0] CS_SINE_IN    = 4'd2;
    localparam logic [3:0] CS_SINE_INOUT = 4'd3;
    localparam logic [3:0] CS_CUBIC_IN   = 4'd4;
    localparam logic [3:0] CS_CUBIC_OUT  = 4'd5;
    localparam logic [3:0] CS_CUBIC_INOUT = 4'd6;
    localparam logic [3:0] CS_BOUNCE_OUT = 4'd7;
    localparam logic [3:0] CS_BOUNCE_IN  = 4'd8;
    localparam logic [3:0] CS_SPRING_IN  = 4'd9;
    localparam logic [3:0] CS_SPRING_OUT = 4'd10;
    localparam logic [3:0] CS_RESET      = CS_CUBIC_INOUT;

    typedef enum logic [2:0] {
        K_LIN,
        K_SIN,
        K_CUB,
        K_BNC,
        K_SPR
    } kind_t;

    // variant codes, meaning depends on kind
    localparam logic [1:0] V_A  = 2'd0;
    localparam logic [1:0] V_B  = 2'd1;
    localparam logic [1:0] V_LO = 2'd2;
    localparam logic [1:0] V_HI = 2'd3;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  vsel;
        logic [16:0] b;
    } ecu_req_t;

    typedef logic [16:0] rom_t [0:SIN_N];

    // shift-subtract quotient, used only while building the table
    function automatic longint unsigned tbl_udiv(input longint unsigned n,
                                                 input longint unsigned dv);
        longint unsigned q, r;
        q = '0;
        r = '0;
        for (int bp = 63; bp >= 0; bp--) begin
            r = {r[62:0], n[bp]};
            if (r >= dv) begin
                r     = r - dv;
                q[bp] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        longint unsigned ang, ang2, term, v;
        longint sum;
        for (int unsigned k = 0; k <= SIN_N; k++) begin
            ang  = (64'd1686629713 * k + SIN_N / 2) / SIN_N;
            ang2 = (ang * ang) >> 30;
            term = ang;
            sum  = longint'(ang);
            for (int unsigned i = 1; i <= 8; i++) begin
                term = (term * ang2) >> 30;
                term = tbl_udiv(term, 64'((2 * i) * (2 * i + 1)));
                if (i % 2 == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            v = (longint'(sum) + 64'd8192) >> 14;
            if (v > 64'd65536) v = 64'd65536;
            r[k] = v[16:0];
        end
        return r;
    endfunction

    localparam rom_t SIN_ROM = build_rom();

    // round to nearest, ties up
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                      input int unsigned n);
        logic signed [63:0] h;
        h = 64'sd1 <<< (n - 1);
        if (v >= 0) return (v + h) >>> n;
        return -(((-v) + h - 64'sd1) >>> n);
    endfunction

endpackage

>>> hdl/ecu_front.sv
module ecu_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [3:0]       cfg_data,
    input  logic [16:0]      progress,
    output ecu_pkg::ecu_req_t req
);
    import ecu_pkg::*;

    logic [3:0]  curve_reg;
    logic [16:0] x;
    logic [16:0] d;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_reg <= CS_RESET;
        end else if (cfg_valid) begin
            curve_reg <= cfg_data;
        end
    end

    always_comb begin
        x = (progress > ONE_Q16) ? ONE_Q16 : progress;
        d = ONE_Q16 - x;
        req.kind = K_LIN;
        req.vsel = V_A;
        req.b    = x;
        case (curve_reg)
            CS_SINE_OUT: begin
                req.kind = K_SIN;
            end
            CS_SINE_IN: begin
                req.kind = K_SIN;
                req.vsel = V_B;
                req.b    = d;
            end
            CS_SINE_INOUT: begin
                req.kind = K_SIN;
                if (x <= HALF_Q16) begin
                    req.vsel = V_LO;
                    req.b    = ONE_Q16 - {x[15:0], 1'b0};
                end else begin
                    req.vsel = V_HI;
                    req.b    = {x[15:0], 1'b0} - ONE_Q16;
                end
            end
            CS_CUBIC_IN: begin
                req.kind = K_CUB;
            end
            CS_CUBIC_OUT: begin
                req.kind = K_CUB;
                req.vsel = V_B;
                req.b    = d;
            end
            CS_CUBIC_INOUT: begin
                req.kind = K_CUB;
                if (x < HALF_Q16) begin
                    req.vsel = V_LO;
                end else begin
                    req.vsel = V_HI;
                    req.b    = d;
                end
            end
            CS_BOUNCE_OUT: begin
                req.kind = K_BNC;
            end
            CS_BOUNCE_IN: begin
                req.kind = K_BNC;
                req.vsel = V_B;
                req.b    = d;
            end
            CS_SPRING_IN: begin
                req.kind = K_SPR;
            end
            CS_SPRING_OUT: begin
                req.kind = K_SPR;
                req.vsel = V_B;
                req.b    = d;
            end
            default: begin
                req.kind = K_LIN;
            end
        endcase
    end

endmodule

>>> hdl/ecu_queue.sv
module ecu_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ecu_pkg::ecu_req_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output ecu_pkg::ecu_req_t pop_data
);
    import ecu_pkg::*;

    ecu_req_t           mem_reg [0:Q_DEPTH-1];
    logic [Q_AW-1:0]    wr_reg;
    logic [Q_AW-1:0]    rd_reg;
    logic [Q_AW:0]      cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (cnt_reg == (Q_AW + 1)'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) wr_reg <= wr_reg + 1'b1;
            if (do_pop) rd_reg <= rd_reg + 1'b1;
            if (do_push && !do_pop) cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

>>> hdl/ecu_back.sv
module ecu_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  ecu_pkg::ecu_req_t q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [17:0]      out_data
);
    import ecu_pkg::*;

    typedef struct packed {
        logic               vld;
        kind_t              kind;
        logic [1:0]         vsel;
        logic [16:0]        b;
        logic [16:0]        off;
        logic [16:0]        lo;
        logic [16:0]        dif;
        logic [15:0]        frac;
        logic signed [63:0] acc;
        logic signed [63:0] y;
    } stg_t;

    stg_t s1_reg, s2_reg, s3_reg, s4_reg;
    stg_t s1_next, s2_next, s3_next, s4_next;
    logic        out_vld_reg;
    logic [17:0] out_data_reg;
    logic        adv;

    logic [POS_W-1:0] pos;
    logic [IDX_W-1:0] idx;
    logic [16:0]      hi;
    logic [19:0]      p11;
    logic signed [21:0] qv;
    logic [32:0]      mprod;
    logic [16:0]      s_val;
    logic [63:0]      c;
    logic signed [63:0] ysat;

    assign adv       = !out_vld_reg || out_ready;
    assign q_pop     = adv && !q_empty;
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // stage 1: table read, squares, bounce segment, spring inner term
    always_comb begin
        s1_next      = '0;
        s1_next.vld  = !q_empty;
        s1_next.kind = q_data.kind;
        s1_next.vsel = q_data.vsel;
        s1_next.b    = q_data.b;
        pos  = POS_W'(q_data.b) * POS_W'(SIN_N);
        idx  = pos[POS_W-1:16];
        hi   = '0;
        p11  = 20'(q_data.b) * 20'd11;
        qv   = '0;
        case (q_data.kind)
            K_SIN: begin
                if (idx >= IDX_W'(SIN_N)) begin
                    s1_next.lo = SIN_ROM[SIN_N];
                    hi         = SIN_ROM[SIN_N];
                end else begin
                    s1_next.lo = SIN_ROM[idx];
                    hi         = SIN_ROM[idx + 1'b1];
                end
                if (hi < s1_next.lo) hi = s1_next.lo;
                s1_next.dif  = hi - s1_next.lo;
                s1_next.frac = pos[15:0];
            end
            K_CUB: begin
                s1_next.acc = 64'(34'(q_data.b) * 34'(q_data.b));
            end
            K_BNC: begin
                if (p11 < 20'd262144) begin
                    qv          = $signed({1'b0, p11, 1'b0});
                    s1_next.off = 17'd0;
                end else if (p11 < 20'd524288) begin
                    qv          = $signed({1'b0, p11, 1'b0}) - 22'sd786432;
                    s1_next.off = 17'd49152;
                end else if (p11 < 20'd655360) begin
                    qv          = $signed({1'b0, p11, 1'b0}) - 22'sd1179648;
                    s1_next.off = 17'd61440;
                end else begin
                    qv          = $signed({1'b0, p11, 1'b0}) - 22'sd1376256;
                    s1_next.off = 17'd64512;
                end
                s1_next.acc = 64'(qv);
            end
            K_SPR: begin
                s1_next.acc = 64'($signed(27'(SPRING1_Q24)) * $signed({1'b0, q_data.b}))
                              - SPRING_Q24 * 64'sd65536;
            end
            default: begin
                s1_next.y = 64'(q_data.b);
            end
        endcase
    end

    // stage 2: interpolation, cube, bounce square, spring rounding
    always_comb begin
        s2_next = s1_reg;
        mprod   = 33'(s1_reg.dif) * 33'(s1_reg.frac);
        case (s1_reg.kind)
            K_SIN: begin
                s2_next.y = 64'(s1_reg.lo) + 64'((mprod + 33'd32768) >> 16);
            end
            K_CUB: begin
                s2_next.acc = 64'(s1_reg.acc[33:0] * 51'(s1_reg.b));
            end
            K_BNC: begin
                s2_next.acc = 64'($signed(s1_reg.acc[21:0]) * $signed(s1_reg.acc[21:0]));
            end
            K_SPR: begin
                s2_next.acc = rnd_shift((s1_reg.vsel == V_B) ? -s1_reg.acc : s1_reg.acc, 16);
            end
            default: begin
            end
        endcase
    end

    // stage 3: finish sine, cubic, bounce; spring first product
    always_comb begin
        s3_next = s2_reg;
        s_val   = s2_reg.y[16:0];
        c       = s2_reg.acc;
        case (s2_reg.kind)
            K_SIN: begin
                case (s2_reg.vsel)
                    V_A:  s3_next.y = 64'(s_val);
                    V_B:  s3_next.y = 64'(ONE_Q16) - 64'(s_val);
                    V_LO: s3_next.y = (64'(ONE_Q16) - 64'(s_val) + 64'sd1) >>> 1;
                    default: s3_next.y = (64'(ONE_Q16) + 64'(s_val) + 64'sd1) >>> 1;
                endcase
            end
            K_CUB: begin
                case (s2_reg.vsel)
                    V_A:  s3_next.y = 64'((c + 64'h8000_0000) >> 32);
                    V_B:  s3_next.y = 64'(((64'd1 << 48) - c + 64'h8000_0000) >> 32);
                    V_LO: s3_next.y = 64'((c + 64'h2000_0000) >> 30);
                    default: s3_next.y = 64'(((64'd1 << 46) - c + 64'h2000_0000) >> 30);
                endcase
            end
            K_BNC: begin
                s3_next.y = 64'((c + 64'd2097152) >> 22) + 64'(s2_reg.off);
                if (s2_reg.vsel == V_B) s3_next.y = 64'(ONE_Q16) - s3_next.y;
            end
            K_SPR: begin
                s3_next.acc = 64'($signed(s2_reg.acc[26:0]) * $signed({1'b0, s2_reg.b}));
            end
            default: begin
            end
        endcase
    end

    // stage 4: spring second product
    always_comb begin
        s4_next = s3_reg;
        if (s3_reg.kind == K_SPR) begin
            s4_next.acc = 64'($signed(s3_reg.acc[43:0]) * $signed({1'b0, s3_reg.b}));
        end
    end

    // stage 5: spring rounding and saturation
    always_comb begin
        ysat = s4_reg.y;
        if (s4_reg.kind == K_SPR) begin
            ysat = rnd_shift(s4_reg.acc, 40);
            if (s4_reg.vsel == V_B) ysat = ysat + 64'sd65536;
        end
        if (ysat < OUT_MIN) ysat = OUT_MIN;
        if (ysat > OUT_MAX) ysat = OUT_MAX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.vld  <= 1'b0;
            s2_reg.vld  <= 1'b0;
            s3_reg.vld  <= 1'b0;
            s4_reg.vld  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            s3_reg       <= s3_next;
            s4_reg       <= s4_next;
            out_vld_reg  <= s4_reg.vld;
            out_data_reg <= ysat[17:0];
        end
    end

endmodule

>>> hdl/easing_curve_unit_core.sv
// result path: queue, then stage registers s1_reg to s4_reg, then the output register; output stalls hold it back
// throughput: one request per cycle while the output is not stalled, set by the five-stage evaluation pipeline
// a four-entry queue between classification and evaluation absorbs output stalls
// reset: synchronous active-low aresetn clears the queue and pipeline valids
// reset sets curve_select to cubic in-out
module easing_curve_unit_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,    // curve_select
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // [16:0] progress
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata      // [17:0] eased_value
);
    import ecu_pkg::*;

    ecu_req_t    f_req;
    ecu_req_t    q_data;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    logic [17:0] eased;

    assign s_tready = !q_full;
    assign m_tdata  = {6'd0, eased};

    ecu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .progress  (s_tdata[16:0]),
        .req       (f_req)
    );

    ecu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data (f_req),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_data)
    );

    ecu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (eased)
    );

endmodule
